// ===== rtl/positional_list_store_core_assert.svh =====
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pls_pkg.sv =====
// Shared constants, operation codes and control structs for the positional list store.
package pls_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int FUNC_W        = 3;
   localparam int POS_W         = 7;
   localparam int VAL_W         = 32;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 48;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET    = 3'd0,
      FUNC_LOCATE = 3'd1,
      FUNC_INSERT = 3'd2,
      FUNC_DELETE = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      IDX_POS_M1 = 2'd0,
      IDX_CNT_M1 = 2'd1,
      IDX_ZERO   = 2'd2
   } idx_sel_type;

   typedef struct packed {
      logic        capture;
      logic        idx_load;
      idx_sel_type idx_sel;
      logic        idx_inc;
      logic        idx_dec;
      logic        rd_en;
      logic        wr_shift;
      logic        wr_val;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        cnt_clr;
      logic        set_ok;
      logic        save_read;
      logic        set_found;
      logic        res_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] op;
      logic              pos_ok;
      logic              ins_ok;
      logic              ins_append;
      logic              list_empty;
      logic              idx_last_up;
      logic              idx_last_down;
      logic              match;
      logic              out_busy;
   } status_type;

endpackage

// ===== rtl/pls_ctrl.sv =====
// Controller state machine that sequences each request through the list datapath.
module pls_ctrl
   import pls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_RD1    = 8'b0000_0100,
      S_RD2    = 8'b0000_1000,
      S_WALK   = 8'b0001_0000,
      S_DRAIN  = 8'b0010_0000,
      S_WRVAL  = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               FUNC_GET, FUNC_DELETE: begin
                  if (status.pos_ok) begin
                     cmd.idx_load = 1'b1;
                     cmd.idx_sel  = IDX_POS_M1;
                     state_in     = S_RD1;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               FUNC_LOCATE: begin
                  cmd.set_ok = 1'b1;
                  if (status.list_empty) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.idx_load = 1'b1;
                     cmd.idx_sel  = IDX_ZERO;
                     state_in     = S_WALK;
                  end
               end
               FUNC_INSERT: begin
                  if (!status.ins_ok) begin
                     state_in = S_FINISH;
                  end else if (status.ins_append) begin
                     state_in = S_WRVAL;
                  end else begin
                     cmd.idx_load = 1'b1;
                     cmd.idx_sel  = IDX_CNT_M1;
                     state_in     = S_WALK;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  cmd.set_ok  = 1'b1;
                  state_in    = S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_RD1: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RD2;
         end
         S_RD2: begin
            cmd.save_read = 1'b1;
            cmd.set_ok    = 1'b1;
            if (status.op == FUNC_DELETE && !status.idx_last_up) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_WALK;
            end else begin
               cmd.cnt_dec = (status.op == FUNC_DELETE);
               state_in    = S_FINISH;
            end
         end
         S_WALK: begin
            if (status.op == FUNC_LOCATE && status.match) begin
               cmd.set_found = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.wr_shift = (status.op != FUNC_LOCATE);
               if (status.op == FUNC_INSERT) begin
                  if (status.idx_last_down) begin
                     state_in = S_DRAIN;
                  end else begin
                     cmd.idx_dec = 1'b1;
                  end
               end else begin
                  if (status.idx_last_up) begin
                     state_in = S_DRAIN;
                  end else begin
                     cmd.idx_inc = 1'b1;
                  end
               end
            end
         end
         S_DRAIN: begin
            case (status.op)
               FUNC_INSERT: begin
                  cmd.wr_shift = 1'b1;
                  state_in     = S_WRVAL;
               end
               FUNC_DELETE: begin
                  cmd.wr_shift = 1'b1;
                  cmd.cnt_dec  = 1'b1;
                  state_in     = S_FINISH;
               end
               default: begin
                  cmd.set_found = status.match;
                  state_in      = S_FINISH;
               end
            endcase
         end
         S_WRVAL: begin
            cmd.wr_val  = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.set_ok  = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pls_datapath.sv =====
// Datapath of the positional list store: entry memory, count, walk index and result register.
module pls_datapath
   import pls_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [VAL_W-1:0]      entries_mem [DEPTH];

   logic [FUNC_W-1:0]     op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [VAL_W-1:0]      val_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [ADDR_W-1:0]     idx_ff;
   logic [ADDR_W-1:0]     prev_ff;
   logic                  rv_ff;
   logic [VAL_W-1:0]      rdata_ff;
   logic                  ok_ff;
   logic [VAL_W-1:0]      rd_value_ff;
   logic [POS_W-1:0]      found_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [ADDR_W-1:0]     pos_m1;
   logic [ADDR_W-1:0]     wr_addr;
   logic [VAL_W-1:0]      wr_data;
   logic                  wr_en;

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign pos_m1  = ADDR_W'(pos_ext - CMP_W'(1));

   // Shift writes land one slot above (insert) or below (delete) the last read.
   always_comb begin
      if (cmd.wr_val) begin
         wr_addr = pos_m1;
         wr_data = val_ff;
      end else if (op_ff == FUNC_INSERT) begin
         wr_addr = prev_ff + ADDR_W'(1);
         wr_data = rdata_ff;
      end else begin
         wr_addr = prev_ff - ADDR_W'(1);
         wr_data = rdata_ff;
      end
      wr_en = cmd.wr_val | (cmd.wr_shift & rv_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entries_mem[idx_ff];
         prev_ff  <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.rd_en;
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser;
         pos_ff      <= req_tdata[POS_W-1:0];
         val_ff      <= req_tdata[POS_W +: VAL_W];
         ok_ff       <= 1'b0;
         rd_value_ff <= '0;
         found_ff    <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.save_read) begin
            rd_value_ff <= rdata_ff;
         end
         if (cmd.set_found) begin
            found_ff <= POS_W'(CMP_W'(prev_ff) + CMP_W'(1));
         end
      end
      if (cmd.idx_load) begin
         case (cmd.idx_sel)
            IDX_POS_M1: idx_ff <= pos_m1;
            IDX_CNT_M1: idx_ff <= ADDR_W'(cnt_ext - CMP_W'(1));
            default:    idx_ff <= '0;
         endcase
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - ADDR_W'(1);
      end
      if (cmd.res_load) begin
         rsp_data_ff <= {(cnt_ff == '0), POS_W'(cnt_ff), found_ff, rd_value_ff, ok_ff};
      end
   end

   always_comb begin
      status.op            = op_ff;
      status.pos_ok        = (pos_ff != '0) && (pos_ext <= cnt_ext);
      status.ins_ok        = (pos_ff != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                             && (cnt_ff != CNT_W'(DEPTH));
      status.ins_append    = (pos_ext == cnt_ext + CMP_W'(1));
      status.list_empty    = (cnt_ff == '0);
      status.idx_last_up   = (CMP_W'(idx_ff) == cnt_ext - CMP_W'(1));
      status.idx_last_down = (CMP_W'(idx_ff) == pos_ext - CMP_W'(1));
      status.match         = rv_ff && (rdata_ff == val_ff);
      status.out_busy      = rsp_valid_ff & ~rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/positional_list_store_core.sv =====
// Top level of the positional list store: an ordered list of signed 32-bit values.
// Requests arrive as beats on the req_ channel; tuser carries the operation
// (get, locate, insert, delete, clear) and tdata the 1-based position and value.
// Each request yields exactly one beat on the rsp_ channel with ok, the value
// read or removed, the position found by locate, the count and an empty flag.
// One request is in flight at a time: req_tready is high only while the
// controller waits for work. Clear and failed requests go straight to the
// result; get reads the addressed entry; insert and delete shift the
// entries from the position to the end of the list; locate scans from the
// front until a match or the end of the list. The walk through the
// single-write, single-read entry memory moves one entry per cycle.
// The result sits in an output register, so the next request is taken while
// an earlier beat still waits; a stalled receiver holds rsp_tdata and only
// blocks the controller when a further result is ready to load.
// Reset empties the list and drops any pending result; memory contents are
// not cleared and need no pass, since no request reads past the count.
`include "positional_list_store_core_assert.svh"
module positional_list_store_core
   import pls_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [6:0] position, [38:7] value, [39] zero
   input  logic [FUNC_W-1:0]     req_tuser,   // [2:0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] ok, [32:1] read_value,
                                              // [39:33] found_position,
                                              // [46:40] count, [47] is_empty
);

   cmd_type    cmd;
   status_type status;

   // Sequence each request: decode, walk the memory, load the result.
   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the entries, the count and the output register.
   pls_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // A taken request closes the input until its result is loaded.
   `PLS_ASSERT_NXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request taken while busy")
   // Never overwrite a result beat that the receiver has not taken.
   `PLS_ASSERT_IMP(a_no_overwrite, cmd.res_load, !(rsp_tvalid && !rsp_tready), "result overwritten")
   // The value write and a shift write never share the single write port.
   `PLS_ASSERT_IMP(a_one_write, cmd.wr_shift, !cmd.wr_val, "write port conflict")

endmodule

// ===== dv/positional_list_store_core_tb.sv =====
// Self-checking testbench for positional_list_store_core, checked beat by beat against an in-bench list.
module positional_list_store_core_tb;
   import pls_pkg::*;

   localparam int          LIST_DEPTH     = DEPTH_DEFAULT;
   localparam int          CYCLE_LIMIT    = 1_000_000;
   localparam int          DRAIN_CYCLES   = 100;
   localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;
   localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_NEG_ONE    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [6:0]  found_position;
      logic [6:0]  count;
      logic        is_empty;
   } list_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted list contents and length
   logic [31:0]  list_mem [LIST_DEPTH];
   int           list_len = 0;
   list_rsp_type expected_rsp_q [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int stall_left     = 0;
   bit sender_gaps_on = 1'b0;
   bit rsp_stalls_on  = 1'b0;

   positional_list_store_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Apply one request to the predicted list and return the response it should give.
   function automatic list_rsp_type apply_list_op(input logic [2:0] func, input logic [6:0] pos,
                                                  input logic [31:0] val);
      list_rsp_type r;
      int           p;
      int           k;
      r = '0;
      p = pos;
      case (func)
         FUNC_GET: begin
            if (p >= 1 && p <= list_len) begin
               r.ok         = 1'b1;
               r.read_value = list_mem[p-1];
            end
         end
         FUNC_LOCATE: begin
            r.ok = 1'b1;
            for (k = 0; k < list_len; k++) begin
               if (list_mem[k] == val) begin
                  r.found_position = 7'(k + 1);
                  break;
               end
            end
         end
         FUNC_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
               for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p-1] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               r.read_value = list_mem[p-1];
               for (k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
               list_len--;
               r.ok = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            list_len = 0;
            r.ok     = 1'b1;
         end
         default: ;
      endcase
      r.count    = 7'(list_len);
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   // Send one request beat; keep valid up through a burst, drop it for a random gap after.
   task automatic send_list_op(input logic [2:0] func, input logic [6:0] pos,
                               input logic [31:0] val);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {1'b0, val, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp_q.push_back(apply_list_op(func, pos, val));
      if (burst_left > 0) burst_left--;
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 1 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
      if (sel == 2) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_NEG_ONE;
            default: return 32'd0;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly legal positions for the current length, with some anywhere in the field.
   function automatic logic [6:0] pick_position(input logic [2:0] func);
      if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
      if (func == FUNC_INSERT) return 7'($urandom_range(1, list_len + 1));
      if ((func == FUNC_GET || func == FUNC_DELETE) && list_len > 0)
         return 7'($urandom_range(1, list_len));
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic logic [2:0] pick_func();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) return FUNC_GET;
      if (sel < 40) return FUNC_LOCATE;
      if (sel < 68) return FUNC_INSERT;
      if (sel < 94) return FUNC_DELETE;
      if (sel < 97) return FUNC_CLEAR;
      return 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
   endfunction

   task automatic send_random_op();
      logic [2:0] func;
      func = pick_func();
      send_list_op(func, pick_position(func), pick_value());
   endtask

   // Empty-list failures, value extremes, front/middle/end insert and delete, bad positions.
   task automatic test_directed_edges();
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      send_list_op(FUNC_GET,       7'd1,  32'd0);
      send_list_op(FUNC_DELETE,    7'd1,  32'd0);
      send_list_op(FUNC_LOCATE,    7'd0,  32'd0);
      send_list_op(FUNC_INSERT,    7'd0,  32'd5);
      send_list_op(FUNC_INSERT,    7'd2,  32'd5);
      send_list_op(FUNC_UNUSED_LO, 7'd1,  32'd1);
      send_list_op(FUNC_UNUSED_HI, 7'd127, VAL_NEG_ONE);
      send_list_op(FUNC_INSERT,    7'd1,  VAL_MIN);
      send_list_op(FUNC_INSERT,    7'd2,  VAL_MAX);
      send_list_op(FUNC_INSERT,    7'd1,  VAL_NEG_ONE);
      send_list_op(FUNC_INSERT,    7'd2,  32'd0);
      send_list_op(FUNC_GET,       7'd0,  32'd0);
      send_list_op(FUNC_GET,       7'd4,  32'd0);
      send_list_op(FUNC_GET,       7'd5,  32'd0);
      send_list_op(FUNC_GET,       7'd127, 32'd0);
      send_list_op(FUNC_LOCATE,    7'd0,  VAL_MAX);
      send_list_op(FUNC_LOCATE,    7'd0,  VAL_NEG_ONE);
      send_list_op(FUNC_LOCATE,    7'd0,  32'd12345);
      send_list_op(FUNC_INSERT,    7'd6,  32'd7);
      send_list_op(FUNC_INSERT,    7'd5,  32'd0);
      send_list_op(FUNC_LOCATE,    7'd0,  32'd0);
      send_list_op(FUNC_DELETE,    7'd5,  32'd0);
      send_list_op(FUNC_DELETE,    7'd1,  32'd0);
      send_list_op(FUNC_DELETE,    7'd2,  32'd0);
      send_list_op(FUNC_CLEAR,     7'd3,  32'd0);
      send_list_op(FUNC_GET,       7'd1,  32'd0);
   endtask

   // Bulk loads to a full list, inserts refused when full, mixed work, then drain by delete.
   task automatic test_bulk_load_rounds(input int rounds);
      int r;
      for (r = 0; r < rounds; r++) begin
         sender_gaps_on = (r % 3 != 0);
         rsp_stalls_on  = (r % 3 != 1);
         send_list_op(FUNC_CLEAR, 7'($urandom_range(0, 127)), $urandom);
         while (list_len < LIST_DEPTH) send_list_op(FUNC_INSERT, 7'(list_len + 1), pick_value());
         send_list_op(FUNC_INSERT, 7'd1, pick_value());
         send_list_op(FUNC_INSERT, 7'(LIST_DEPTH + 1), pick_value());
         send_list_op(FUNC_INSERT, 7'($urandom_range(2, LIST_DEPTH)), pick_value());
         send_list_op(FUNC_GET, 7'(LIST_DEPTH), $urandom);
         send_list_op(FUNC_GET, 7'(LIST_DEPTH + 1), $urandom);
         send_list_op(FUNC_LOCATE, 7'd0, list_mem[LIST_DEPTH - 1]);
         repeat (30) send_random_op();
         while (list_len > 0)
            send_list_op(FUNC_DELETE, 7'($urandom_range(1, list_len)), $urandom);
      end
   endtask

   // Random mix; idling on each side is switched off for one 200-beat block in every three.
   task automatic test_random_traffic(input int n_items);
      int i;
      for (i = 0; i < n_items; i++) begin
         sender_gaps_on = ((i / 200) % 3 != 1);
         rsp_stalls_on  = ((i / 200) % 3 != 2);
         send_random_op();
      end
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Receiver: random stall windows while enabled.
   always @(posedge clock) begin
      if (reset || !rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected, expected none actual %0h",
                     $time, rsp_tdata);
         end else begin
            want = expected_rsp_q.pop_front();
            report_field("ok",             32'(want.ok),             32'(rsp_tdata[0]));
            report_field("read_value",     want.read_value,          rsp_tdata[32:1]);
            report_field("found_position", 32'(want.found_position), 32'(rsp_tdata[39:33]));
            report_field("count",          32'(want.count),          32'(rsp_tdata[46:40]));
            report_field("is_empty",       32'(want.is_empty),       32'(rsp_tdata[47]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_bulk_load_rounds(3);
      test_random_traffic(1300);
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_ctrl.sv
rtl/pls_datapath.sv
rtl/positional_list_store_core.sv
dv/positional_list_store_core_tb.sv
